// ----- design/julian_day_number_converter_top_macros.svh -----
// Assertion helpers for the calendar converter.
`ifndef JULIAN_DAY_NUMBER_CONVERTER_TOP_MACROS_SVH
`define JULIAN_DAY_NUMBER_CONVERTER_TOP_MACROS_SVH

// same-cycle implication
`define JDNC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jdnc assertion failed");

// next-cycle implication
`define JDNC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jdnc assertion failed");

`endif

// ----- design/jdnc_pkg.sv -----
`default_nettype none
package jdnc_pkg;

    // register stages in front of the output register
    localparam int unsigned LAT         = 7;
    localparam int unsigned TO_JDN_DLY  = LAT - 4;

    localparam logic OP_TO_JDN  = 1'b0;
    localparam logic OP_TO_DATE = 1'b1;

    localparam logic [22:0] JDN_MIN     = 23'd1721426;
    localparam logic [22:0] JDN_MAX     = 23'd5373484;
    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [3:0]  MONTH_MAX   = 4'd12;
    localparam logic [12:0] YEAR_OFS    = 13'd4800;
    localparam logic [15:0] JDN_OFS_ENC = 16'd32045;
    localparam logic [15:0] JDN_OFS_DEC = 16'd32044;
    localparam logic [17:0] DAYS_400Y   = 18'd146097;
    localparam logic [10:0] DAYS_4Y     = 11'd1461;
    localparam logic [8:0]  DAYS_YEAR   = 9'd365;
    localparam logic [6:0]  CENTURY     = 7'd100;
    localparam logic [3:0]  WEEK_DAYS   = 4'd7;

    // reciprocals: floor(x/d) = (x * ceil(2^sh/d)) >> sh over the operand span
    localparam int unsigned     RCP100_SH = 22;
    localparam longint unsigned RCP100    = ((64'd1 << RCP100_SH) + 64'd99) / 64'd100;
    localparam int unsigned     RCPB_SH   = 43;
    localparam longint unsigned RCPB      = ((64'd1 << RCPB_SH) + 64'd146096) / 64'd146097;
    localparam int unsigned     RCPD_SH   = 29;
    localparam longint unsigned RCPD      = ((64'd1 << RCPD_SH) + 64'd1460) / 64'd1461;
    localparam int unsigned     RCPM_SH   = 19;
    localparam longint unsigned RCPM      = ((64'd1 << RCPM_SH) + 64'd152) / 64'd153;

    typedef struct packed {
        logic        opcode;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [22:0] day_number;
    } t_jdnc_in;

    typedef struct packed {
        logic [22:0] out_day_number;
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [2:0]  weekday;
        logic        range_error;
    } t_jdnc_out;

    typedef struct packed {
        logic [22:0] day_number;
        logic [2:0]  weekday;
    } t_jdnc_num;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
    } t_jdnc_date;

    // day offset of a March-based month: (153*m + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // 8 = 1 mod 7: fold octal digits
    function automatic logic [2:0] mod7(input logic [22:0] x);
        logic [23:0] xe;
        logic [5:0]  s;
        logic [3:0]  t;
        logic [3:0]  u;
        xe = {1'b0, x};
        s  = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + 6'(xe[3*k +: 3]);
        end
        t = 4'(s[5:3]) + 4'(s[2:0]);
        u = 4'(t[3]) + 4'(t[2:0]);
        return (u >= WEEK_DAYS) ? 3'(u - WEEK_DAYS) : u[2:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/jdnc_to_jdn.sv -----
`default_nettype none
module jdnc_to_jdn (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [13:0]          i_year,
    input  logic [3:0]           i_month,
    input  logic [4:0]           i_day,
    output jdnc_pkg::t_jdnc_num  o_res
);

    logic        early;
    logic [14:0] n_s1_y;
    logic [3:0]  n_s1_mm;

    logic [14:0] r_s1_y;
    logic [3:0]  r_s1_mm;
    logic [4:0]  r_s1_day;

    logic [23:0] r_s2_y365;
    logic [30:0] r_s2_q100p;
    logic [28:0] r_s2_q400p;
    logic [12:0] r_s2_y4;
    logic [9:0]  r_s2_dt;

    logic [22:0] r_s3_jdn;

    jdnc_pkg::t_jdnc_num r_dly [jdnc_pkg::TO_JDN_DLY + 1];

    // March-based year and month
    always_comb begin
        early   = (i_month < 4'd3);
        n_s1_y  = 15'(i_year) + 15'(jdnc_pkg::YEAR_OFS) - 15'(early);
        n_s1_mm = early ? (i_month + 4'd9) : (i_month - 4'd3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_y     <= n_s1_y;
            r_s1_mm    <= n_s1_mm;
            r_s1_day   <= i_day;

            r_s2_y365  <= 24'(r_s1_y) * 24'(jdnc_pkg::DAYS_YEAR);
            r_s2_q100p <= 31'(r_s1_y) * 31'(jdnc_pkg::RCP100);
            r_s2_q400p <= 29'(r_s1_y[14:2]) * 29'(jdnc_pkg::RCP100);
            r_s2_y4    <= r_s1_y[14:2];
            r_s2_dt    <= 10'(jdnc_pkg::month_start(r_s1_mm)) + 10'(r_s1_day);

            r_s3_jdn   <= 23'(25'(r_s2_y365) + 25'(r_s2_y4)
                              + 25'(r_s2_q400p[28:jdnc_pkg::RCP100_SH]) + 25'(r_s2_dt)
                              - 25'(r_s2_q100p[30:jdnc_pkg::RCP100_SH])
                              - 25'(jdnc_pkg::JDN_OFS_ENC));

            r_dly[0].day_number <= r_s3_jdn;
            r_dly[0].weekday    <= jdnc_pkg::mod7(r_s3_jdn);
            for (int k = 1; k <= jdnc_pkg::TO_JDN_DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_res = r_dly[jdnc_pkg::TO_JDN_DLY];

endmodule
`default_nettype wire

// ----- design/jdnc_to_date.sv -----
`default_nettype none
module jdnc_to_date (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [22:0]           i_day_number,
    output jdnc_pkg::t_jdnc_date  o_res
);

    logic [7:0]  b;
    logic [6:0]  d;
    logic [3:0]  m;
    logic        late;
    logic [10:0] e5;

    logic [22:0] r_s1_a;
    logic [2:0]  r_s1_wd;

    logic [50:0] r_s2_pb;
    logic [22:0] r_s2_a;
    logic [2:0]  r_s2_wd;

    logic [7:0]  r_s3_b;
    logic [15:0] r_s3_c;
    logic [2:0]  r_s3_wd;

    logic [36:0] r_s4_pd;
    logic [15:0] r_s4_c;
    logic [13:0] r_s4_yb;
    logic [2:0]  r_s4_wd;

    logic [8:0]  r_s5_e;
    logic [13:0] r_s5_yb;
    logic [2:0]  r_s5_wd;

    logic [22:0] r_s6_pm;
    logic [8:0]  r_s6_e;
    logic [13:0] r_s6_yb;
    logic [2:0]  r_s6_wd;

    jdnc_pkg::t_jdnc_date r_s7;

    always_comb begin
        b    = r_s2_pb[50:jdnc_pkg::RCPB_SH];
        d    = r_s4_pd[35:jdnc_pkg::RCPD_SH];
        e5   = 11'({r_s5_e, 2'b00}) + 11'(r_s5_e) + 11'd2;
        m    = r_s6_pm[22:jdnc_pkg::RCPM_SH];
        late = (m >= 4'd10);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_a  <= i_day_number + 23'(jdnc_pkg::JDN_OFS_DEC);
            r_s1_wd <= jdnc_pkg::mod7(i_day_number);

            // 400-year cycles
            r_s2_pb <= 51'({r_s1_a, 2'b11}) * 51'(jdnc_pkg::RCPB);
            r_s2_a  <= r_s1_a;
            r_s2_wd <= r_s1_wd;

            r_s3_b  <= b;
            r_s3_c  <= 16'(r_s2_a - 23'((26'(b) * 26'(jdnc_pkg::DAYS_400Y)) >> 2));
            r_s3_wd <= r_s2_wd;

            // 4-year cycles
            r_s4_pd <= 37'({r_s3_c, 2'b11}) * 37'(jdnc_pkg::RCPD);
            r_s4_c  <= r_s3_c;
            r_s4_yb <= 14'(r_s3_b) * 14'(jdnc_pkg::CENTURY);
            r_s4_wd <= r_s3_wd;

            r_s5_e  <= 9'(r_s4_c - 16'((18'(d) * 18'(jdnc_pkg::DAYS_4Y)) >> 2));
            r_s5_yb <= r_s4_yb + 14'(d);
            r_s5_wd <= r_s4_wd;

            // March-based month
            r_s6_pm <= 23'(e5) * 23'(jdnc_pkg::RCPM);
            r_s6_e  <= r_s5_e;
            r_s6_yb <= r_s5_yb;
            r_s6_wd <= r_s5_wd;

            r_s7.year    <= 14'(15'(r_s6_yb) + 15'(late) - 15'(jdnc_pkg::YEAR_OFS));
            r_s7.month   <= late ? (m - 4'd9) : (m + 4'd3);
            r_s7.day     <= 5'(r_s6_e + 9'd1 - jdnc_pkg::month_start(m));
            r_s7.weekday <= r_s6_wd;
        end
    end

    assign o_res = r_s7;

endmodule
`default_nettype wire

// ----- design/julian_day_number_converter_top.sv -----
// Gregorian date <-> Julian day number converter.
// Input channel (i_valid/o_ready, i_data): opcode 0 takes year/month/day and
// returns the day number; opcode 1 takes a day number and returns
// year/month/day. Both report the weekday (0 = Monday). Out-of-span inputs
// give range_error with all other result fields zero.
// Output channel (o_valid/i_ready, o_data): one result per transaction, in
// order.
// Throughput: one transaction per cycle when the output is not stalled.
// Depth is set by the day-number to date chain: three reciprocal
// multiplies, each followed by a register.
// Reset clears all valid bits and holds o_ready low; the pipeline comes out
// of reset empty and ready.
// When the receiver stalls with a result held in the output register, the
// whole pipeline freezes and o_ready drops; nothing is lost or repeated.
`default_nettype none
`include "julian_day_number_converter_top_macros.svh"
module julian_day_number_converter_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  jdnc_pkg::t_jdnc_in   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output jdnc_pkg::t_jdnc_out  o_data
);

    localparam int unsigned LAT = jdnc_pkg::LAT;

    logic adv;
    logic bad_date;
    logic bad_num;
    logic in_err;

    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_op;
    logic [LAT-1:0] r_err;
    logic           r_out_vld;

    jdnc_pkg::t_jdnc_out  r_out;
    jdnc_pkg::t_jdnc_out  n_out;
    jdnc_pkg::t_jdnc_num  num_res;
    jdnc_pkg::t_jdnc_date date_res;

    assign adv     = !r_out_vld || i_ready;
    assign o_ready = adv && i_rst_n;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_comb begin
        bad_date = (i_data.year == 14'd0) || (i_data.year > jdnc_pkg::YEAR_MAX)
                   || (i_data.month == 4'd0) || (i_data.month > jdnc_pkg::MONTH_MAX)
                   || (i_data.day == 5'd0);
        bad_num  = (i_data.day_number < jdnc_pkg::JDN_MIN)
                   || (i_data.day_number > jdnc_pkg::JDN_MAX);
        in_err   = (i_data.opcode == jdnc_pkg::OP_TO_JDN) ? bad_date : bad_num;
    end

    jdnc_to_jdn u_to_jdn (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_year  (i_data.year),
        .i_month (i_data.month),
        .i_day   (i_data.day),
        .o_res   (num_res)
    );

    jdnc_to_date u_to_date (
        .i_clk        (i_clk),
        .i_en         (adv),
        .i_day_number (i_data.day_number),
        .o_res        (date_res)
    );

    always_comb begin
        n_out = '0;
        priority if (r_err[LAT-1]) begin
            n_out.range_error = 1'b1;
        end else if (r_op[LAT-1] == jdnc_pkg::OP_TO_JDN) begin
            n_out.out_day_number = num_res.day_number;
            n_out.weekday        = num_res.weekday;
        end else begin
            n_out.out_year  = date_res.year;
            n_out.out_month = date_res.month;
            n_out.out_day   = date_res.day;
            n_out.weekday   = date_res.weekday;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[LAT-2:0], i_valid};
            r_out_vld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_op  <= {r_op[LAT-2:0], i_data.opcode};
            r_err <= {r_err[LAT-2:0], in_err};
            r_out <= n_out;
        end
    end

    `JDNC_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && o_data.range_error, o_data.out_day_number == 23'd0 && o_data.out_year == 14'd0 && o_data.out_month == 4'd0 && o_data.out_day == 5'd0 && o_data.weekday == 3'd0)
    `JDNC_ASSERT_IMP(a_wd_span, i_clk, i_rst_n, o_valid, o_data.weekday != 3'd7)
    `JDNC_ASSERT_IMP(a_date_span, i_clk, i_rst_n, o_valid && !o_data.range_error && o_data.out_day_number == 23'd0, o_data.out_year != 14'd0 && o_data.out_year <= jdnc_pkg::YEAR_MAX && o_data.out_month != 4'd0 && o_data.out_month <= jdnc_pkg::MONTH_MAX && o_data.out_day != 5'd0)
    `JDNC_ASSERT_IMP(a_num_span, i_clk, i_rst_n, o_valid && !o_data.range_error && o_data.out_day_number != 23'd0, o_data.out_year == 14'd0 && o_data.out_month == 4'd0 && o_data.out_day == 5'd0 && o_data.out_day_number >= jdnc_pkg::JDN_MIN)
    `JDNC_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(r_vld))

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS   = 600;
    localparam int unsigned QUIET_TAIL     = 100;
    localparam int unsigned LONG_HOLD      = 60;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    localparam jdnc_pkg::t_jdnc_out RANGE_FAULT = '{23'd0, 14'd0, 4'd0, 5'd0, 3'd0, 1'b1};
    localparam jdnc_pkg::t_jdnc_out NO_RESULT   = '{23'd0, 14'd0, 4'd0, 5'd0, 3'd0, 1'b0};

    typedef struct packed {
        jdnc_pkg::t_jdnc_in  item;
        logic                typed;
        jdnc_pkg::t_jdnc_out result;
    } t_vector;

    localparam int unsigned N_VECTORS = 22;

    // typed rows: 0001-01-01 is a Monday, 9999-12-31 a Friday, 2000-01-01 a Saturday
    t_vector vectors [N_VECTORS] = '{
        '{'{jdnc_pkg::OP_TO_JDN, 14'd1, 4'd1, 5'd1, 23'd0}, 1'b1,
          '{23'd1721426, 14'd0, 4'd0, 5'd0, 3'd0, 1'b0}},
        '{'{jdnc_pkg::OP_TO_JDN, 14'd9999, 4'd12, 5'd31, 23'h7FFFFF}, 1'b1,
          '{23'd5373484, 14'd0, 4'd0, 5'd0, 3'd4, 1'b0}},
        '{'{jdnc_pkg::OP_TO_DATE, 14'd0, 4'd0, 5'd0, 23'd1721426}, 1'b1,
          '{23'd0, 14'd1, 4'd1, 5'd1, 3'd0, 1'b0}},
        '{'{jdnc_pkg::OP_TO_DATE, 14'h3FFF, 4'hF, 5'h1F, 23'd5373484}, 1'b1,
          '{23'd0, 14'd9999, 4'd12, 5'd31, 3'd4, 1'b0}},
        '{'{jdnc_pkg::OP_TO_JDN, 14'd2000, 4'd1, 5'd1, 23'd0}, 1'b1,
          '{23'd2451545, 14'd0, 4'd0, 5'd0, 3'd5, 1'b0}},
        '{'{jdnc_pkg::OP_TO_JDN, 14'd0, 4'd6, 5'd15, 23'd0}, 1'b1, RANGE_FAULT},
        '{'{jdnc_pkg::OP_TO_JDN, 14'd10000, 4'd6, 5'd15, 23'd0}, 1'b1, RANGE_FAULT},
        '{'{jdnc_pkg::OP_TO_JDN, 14'h3FFF, 4'hF, 5'h1F, 23'h7FFFFF}, 1'b1, RANGE_FAULT},
        '{'{jdnc_pkg::OP_TO_JDN, 14'd1999, 4'd0, 5'd10, 23'd0}, 1'b1, RANGE_FAULT},
        '{'{jdnc_pkg::OP_TO_JDN, 14'd1999, 4'd13, 5'd10, 23'd0}, 1'b1, RANGE_FAULT},
        '{'{jdnc_pkg::OP_TO_JDN, 14'd1999, 4'd15, 5'd10, 23'd0}, 1'b1, RANGE_FAULT},
        '{'{jdnc_pkg::OP_TO_JDN, 14'd1999, 4'd5, 5'd0, 23'd0}, 1'b1, RANGE_FAULT},
        '{'{jdnc_pkg::OP_TO_DATE, 14'd2000, 4'd1, 5'd1, 23'd1721425}, 1'b1, RANGE_FAULT},
        '{'{jdnc_pkg::OP_TO_DATE, 14'd2000, 4'd1, 5'd1, 23'd5373485}, 1'b1, RANGE_FAULT},
        '{'{jdnc_pkg::OP_TO_DATE, 14'd0, 4'd0, 5'd0, 23'd0}, 1'b1, RANGE_FAULT},
        '{'{jdnc_pkg::OP_TO_DATE, 14'h3FFF, 4'hF, 5'h1F, 23'h7FFFFF}, 1'b1, RANGE_FAULT},
        // Feb 31 rolls into March
        '{'{jdnc_pkg::OP_TO_JDN, 14'd2023, 4'd2, 5'd31, 23'd0}, 1'b0, NO_RESULT},
        '{'{jdnc_pkg::OP_TO_JDN, 14'd2024, 4'd2, 5'd29, 23'h7FFFFF}, 1'b0, NO_RESULT},
        '{'{jdnc_pkg::OP_TO_JDN, 14'd1, 4'd2, 5'd31, 23'h555555}, 1'b0, NO_RESULT},
        '{'{jdnc_pkg::OP_TO_JDN, 14'd1582, 4'd10, 5'd15, 23'd0}, 1'b0, NO_RESULT},
        '{'{jdnc_pkg::OP_TO_DATE, 14'h3FFF, 4'hF, 5'h1F, 23'd2451545}, 1'b0, NO_RESULT},
        '{'{jdnc_pkg::OP_TO_DATE, 14'h2AAA, 4'hA, 5'h15, 23'd2299161}, 1'b0, NO_RESULT}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    jdnc_pkg::t_jdnc_in  i_data;
    logic                o_valid;
    logic                i_ready;
    jdnc_pkg::t_jdnc_out o_data;

    logic                drv_typed;
    jdnc_pkg::t_jdnc_out drv_result;

    bit                  idle_on;
    bit                  long_hold_req;
    int                  error_count;
    int                  n_to_jdn;
    int                  n_to_date;
    int                  n_out_of_span;
    int                  n_checked;
    int                  stall_cycles;
    jdnc_pkg::t_jdnc_out pending_results [$];
    jdnc_pkg::t_jdnc_out want;

    julian_day_number_converter_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    function automatic jdnc_pkg::t_jdnc_out calc_conversion(input jdnc_pkg::t_jdnc_in x);
        jdnc_pkg::t_jdnc_out r;
        longint unsigned     early;
        longint unsigned     y;
        longint unsigned     m;
        longint unsigned     jdn;
        longint unsigned     a;
        longint unsigned     b;
        longint unsigned     c;
        longint unsigned     d;
        longint unsigned     e;
        r = '0;
        if (x.opcode == jdnc_pkg::OP_TO_JDN) begin
            if (x.year < 1 || x.year > jdnc_pkg::YEAR_MAX || x.month < 1
                    || x.month > jdnc_pkg::MONTH_MAX || x.day < 1) begin
                r.range_error = 1'b1;
            end else begin
                early = (x.month < 3) ? 64'd1 : 64'd0;
                y     = 64'(x.year) + 64'd4800 - early;
                m     = 64'(x.month) + 64'd12 * early - 64'd3;
                jdn   = 64'(x.day) + (64'd153 * m + 64'd2) / 64'd5 + 64'd365 * y
                        + y / 64'd4 - y / 64'd100 + y / 64'd400 - 64'd32045;
                r.out_day_number = jdn[22:0];
                r.weekday        = 3'(jdn % 64'd7);
            end
        end else begin
            if (x.day_number < jdnc_pkg::JDN_MIN || x.day_number > jdnc_pkg::JDN_MAX) begin
                r.range_error = 1'b1;
            end else begin
                jdn = 64'(x.day_number);
                a   = jdn + 64'd32044;
                b   = (64'd4 * a + 64'd3) / 64'd146097;
                c   = a - (64'd146097 * b) / 64'd4;
                d   = (64'd4 * c + 64'd3) / 64'd1461;
                e   = c - (64'd1461 * d) / 64'd4;
                m   = (64'd5 * e + 64'd2) / 64'd153;
                r.out_year  = 14'(64'd100 * b + d + m / 64'd10 - 64'd4800);
                r.out_month = 4'(m + 64'd3 - 64'd12 * (m / 64'd10));
                r.out_day   = 5'(e - (64'd153 * m + 64'd2) / 64'd5 + 64'd1);
                r.weekday   = 3'(jdn % 64'd7);
            end
        end
        return r;
    endfunction

    function automatic jdnc_pkg::t_jdnc_in make_random_item();
        jdnc_pkg::t_jdnc_in x;
        int unsigned        pick;
        pick         = $urandom_range(0, 9);
        x.opcode     = 1'($urandom);
        x.year       = 14'($urandom);
        x.month      = 4'($urandom);
        x.day        = 5'($urandom);
        x.day_number = 23'($urandom);
        if (pick < 4) begin
            x.opcode = jdnc_pkg::OP_TO_JDN;
            x.year   = 14'($urandom_range(1, 9999));
            x.month  = 4'($urandom_range(1, 12));
            x.day    = 5'($urandom_range(1, 31));
        end else if (pick < 8) begin
            x.opcode     = jdnc_pkg::OP_TO_DATE;
            x.day_number = 23'($urandom_range(jdnc_pkg::JDN_MIN, jdnc_pkg::JDN_MAX));
        end
        return x;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic send_item(input jdnc_pkg::t_jdnc_in item, input logic typed,
                             input jdnc_pkg::t_jdnc_out result);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_data     <= item;
        drv_typed  <= typed;
        drv_result <= result;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (item.opcode == jdnc_pkg::OP_TO_JDN) n_to_jdn++;
        else n_to_date++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        i_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_checked++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result transaction with nothing pending");
                end else begin
                    want = pending_results.pop_front();
                    if (want.range_error) n_out_of_span++;
                    if (o_data.out_day_number !== want.out_day_number)
                        report_mismatch($sformatf("out_day_number got %0d want %0d",
                            o_data.out_day_number, want.out_day_number));
                    if (o_data.out_year !== want.out_year)
                        report_mismatch($sformatf("out_year got %0d want %0d",
                            o_data.out_year, want.out_year));
                    if (o_data.out_month !== want.out_month)
                        report_mismatch($sformatf("out_month got %0d want %0d",
                            o_data.out_month, want.out_month));
                    if (o_data.out_day !== want.out_day)
                        report_mismatch($sformatf("out_day got %0d want %0d",
                            o_data.out_day, want.out_day));
                    if (o_data.weekday !== want.weekday)
                        report_mismatch($sformatf("weekday got %0d want %0d",
                            o_data.weekday, want.weekday));
                    if (o_data.range_error !== want.range_error)
                        report_mismatch($sformatf("range_error got %0b want %0b",
                            o_data.range_error, want.range_error));
                end
            end
            if (i_valid && o_ready) begin
                pending_results.push_back(drv_typed ? drv_result : calc_conversion(i_data));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", stall_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_valid       <= 1'b0;
        i_data        <= '0;
        drv_typed     <= 1'b0;
        drv_result    <= '0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        error_count   = 0;
        n_to_jdn      = 0;
        n_to_date     = 0;
        n_out_of_span = 0;
        n_checked     = 0;
        stall_cycles  = 0;
        @(posedge i_clk iff i_rst_n);

        for (int k = 0; k < N_VECTORS; k++) begin
            send_item(vectors[k].item, vectors[k].typed, vectors[k].result);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 100 || k == 350) long_hold_req = 1'b1;
            if (k == RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
            send_item(make_random_item(), 1'b0, NO_RESULT);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d date-to-day and %0d day-to-date transactions, %0d results checked",
            n_to_jdn, n_to_date, n_checked);
        $display("%0d out-of-span results, %0d mismatches", n_out_of_span, error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/jdnc_pkg.sv
design/jdnc_to_jdn.sv
design/jdnc_to_date.sv
design/julian_day_number_converter_top.sv
tb/sv/testbench.sv
